FILE: hw/rtl/fcb_pkg.sv
`default_nettype none

package fcb_pkg;

  // store geometry
  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

  // fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned HELD_W   = 7;

  localparam logic [HELD_W-1:0] HELD_MAX      = '1;
  localparam logic [BYTE_W-1:0] TERM_BYTE     = 8'h3B;
  localparam logic [BYTE_W-1:0] MARKER_RESET  = 8'h02;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2
  } fcb_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED    = 3'd0,
    STAT_IGNORED   = 3'd1,
    STAT_OVERFLOW  = 3'd2,
    STAT_DELIVERED = 3'd3,
    STAT_DISCARDED = 3'd4,
    STAT_NO_TERM   = 3'd5,
    STAT_CLEARED   = 3'd6
  } fcb_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_SEND_RD,
    ST_SEND,
    ST_FINISH
  } fcb_state_e;

  // controller to datapath
  typedef struct packed {
    logic do_item;    // single-result item, handled in the idle state
    logic pop_start;  // latch capacity, rewind scan index
    logic rd_search;  // read store at scan position
    logic step_idx;   // advance scan index
    logic found;      // terminator hit: remove command from store
    logic rd_cmd;     // read command byte for streaming
    logic ld_byte;    // load streamed byte result
    logic ld_final;   // load closing result of a pop
    logic ld_noterm;  // load no-terminator result
  } fcb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic pending;     // a command is pending
    logic at_end;      // scan index reached fill level
    logic term_hit;    // read data is the terminator
    logic more_bytes;  // command bytes left to stream
  } fcb_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fcb_ctrl.sv
`default_nettype none

module fcb_ctrl
  import fcb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [FUNC_W-1:0] func_i,
  output logic                   in_ready_o,
  input  wire fcb_stat_t         stat_i,
  output fcb_cmd_t               cmd_o
);

  fcb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.slot_free;
        if (in_valid_i && stat_i.slot_free) begin
          if (func_i == FUNC_POP && stat_i.pending) begin
            cmd_o.pop_start = 1'b1;
            state_d         = ST_SEARCH_RD;
          end else begin
            cmd_o.do_item = 1'b1;
          end
        end
      end
      ST_SEARCH_RD: begin
        if (stat_i.at_end) begin
          if (stat_i.slot_free) begin
            cmd_o.ld_noterm = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.rd_search = 1'b1;
          state_d         = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        if (stat_i.term_hit) begin
          cmd_o.found = 1'b1;
          state_d     = ST_SEND_RD;
        end else begin
          cmd_o.step_idx = 1'b1;
          state_d        = ST_SEARCH_RD;
        end
      end
      ST_SEND_RD: begin
        if (stat_i.more_bytes) begin
          cmd_o.rd_cmd = 1'b1;
          state_d      = ST_SEND;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SEND: begin
        if (stat_i.slot_free) begin
          cmd_o.ld_byte  = 1'b1;
          cmd_o.step_idx = 1'b1;
          state_d        = ST_SEND_RD;
        end
      end
      ST_FINISH: begin
        if (stat_i.slot_free) begin
          cmd_o.ld_final = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fcb_dp.sv
`default_nettype none

module fcb_dp
  import fcb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [BYTE_W-1:0]   cfg_wdata_i,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [BYTE_W-1:0]   data_byte_i,
  input  wire logic [CAP_W-1:0]    capacity_i,
  input  wire fcb_cmd_t            cmd_i,
  output fcb_stat_t                stat_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic                     byte_valid_o,
  output logic                     last_o,
  output logic [LEN_W-1:0]         cmd_length_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FILL_W-1:0]        fill_level_o,
  output logic                     overflow_seen_o
);

  // circular addressing: logical entry off lives at base + off
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(BUF_DEPTH)) begin
      sum = sum - (CNT_W+1)'(BUF_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic [BYTE_W-1:0] mem_q [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  logic [BYTE_W-1:0] marker_q;
  logic [CNT_W-1:0]  wp_q, wp_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] cmd_base_q;
  logic              recv_q, recv_d;
  logic              pending_q, pending_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] pos_q;
  logic [CAP_W-1:0]  cap_q;
  logic              fits_q;

  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                byte_valid_q, byte_valid_d;
  logic                last_q, last_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                load;

  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_re;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rm_cnt;
  logic              slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign rm_cnt    = idx_q + CNT_W'(1);
  assign wr_addr   = wrap_add(base_q, wp_q);
  assign mem_re    = cmd_i.rd_search || cmd_i.rd_cmd;
  assign rd_addr   = cmd_i.rd_cmd ? wrap_add(cmd_base_q, idx_q) : wrap_add(base_q, idx_q);

  always_comb begin
    wp_d         = wp_q;
    base_d       = base_q;
    recv_d       = recv_q;
    pending_d    = pending_q;
    held_d       = held_q;
    ovf_d        = ovf_q;
    idx_d        = idx_q;
    mem_we       = 1'b0;
    load         = 1'b0;
    out_byte_d   = '0;
    byte_valid_d = 1'b0;
    last_d       = 1'b1;
    len_d        = '0;
    status_d     = STAT_IGNORED;

    if (cmd_i.do_item) begin
      load = 1'b1;
      case (func_i)
        FUNC_PUSH: begin
          if (!recv_q) begin
            if (data_byte_i == marker_q) begin
              recv_d = 1'b1;
            end
            status_d = STAT_IGNORED;
          end else begin
            if (data_byte_i == TERM_BYTE) begin
              pending_d = 1'b1;
              recv_d    = 1'b0;
              if (held_q != HELD_MAX) begin
                held_d = held_q + HELD_W'(1);
              end
            end
            if (wp_q < CNT_W'(BUF_DEPTH)) begin
              mem_we   = 1'b1;
              wp_d     = wp_q + CNT_W'(1);
              status_d = STAT_STORED;
            end else begin
              ovf_d    = 1'b1;
              status_d = STAT_OVERFLOW;
            end
          end
        end
        FUNC_POP: begin
          // only reaches here with nothing pending
          status_d = STAT_NO_TERM;
        end
        FUNC_CLEAR: begin
          wp_d      = '0;
          pending_d = 1'b0;
          status_d  = STAT_CLEARED;
        end
        default: begin
          status_d = STAT_IGNORED;
        end
      endcase
    end

    if (cmd_i.pop_start) begin
      idx_d = '0;
    end
    if (cmd_i.step_idx) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.found) begin
      // drop command plus terminator from the head of the store
      idx_d  = '0;
      base_d = wrap_add(base_q, rm_cnt);
      wp_d   = wp_q - rm_cnt;
      if (held_q != '0) begin
        held_d = held_q - HELD_W'(1);
      end
      pending_d = (held_d != '0);
    end

    if (cmd_i.ld_noterm) begin
      load     = 1'b1;
      status_d = STAT_NO_TERM;
    end
    if (cmd_i.ld_byte) begin
      load         = 1'b1;
      out_byte_d   = rd_data_q;
      byte_valid_d = 1'b1;
      last_d       = 1'b0;
      status_d     = STAT_DELIVERED;
    end
    if (cmd_i.ld_final) begin
      load     = 1'b1;
      status_d = fits_q ? STAT_DELIVERED : STAT_DISCARDED;
      len_d    = fits_q ? LEN_W'(pos_q) : '0;
    end

    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= data_byte_i;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q    <= MARKER_RESET;
      wp_q        <= '0;
      base_q      <= '0;
      recv_q      <= 1'b0;
      pending_q   <= 1'b0;
      held_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      wp_q        <= wp_d;
      base_q      <= base_d;
      recv_q      <= recv_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_start) begin
      cap_q <= capacity_i;
    end
    if (cmd_i.found) begin
      cmd_base_q <= base_q;
      pos_q      <= idx_q[ADDR_W-1:0];
      fits_q     <= (cap_q > CAP_W'(idx_q));
    end
    if (load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      len_q        <= len_d;
      status_q     <= status_d;
    end
  end

  assign stat_o.slot_free  = slot_free;
  assign stat_o.pending    = pending_q;
  assign stat_o.at_end     = (idx_q == wp_q);
  assign stat_o.term_hit   = (rd_data_q == TERM_BYTE);
  assign stat_o.more_bytes = fits_q && (idx_q != CNT_W'(pos_q));

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign last_o          = last_q;
  assign cmd_length_o    = len_q;
  assign status_o        = status_q;
  assign fill_level_o    = FILL_W'(wp_q);
  assign overflow_seen_o = ovf_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= CNT_W'(BUF_DEPTH))
    else $error("fill level beyond store depth");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag dropped");

  a_found_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.found |-> (rd_data_q == TERM_BYTE) && (idx_q < wp_q))
    else $error("command removed without terminator in range");

  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> !pending_q)
    else $error("command pending with zero count");

  a_mid_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> byte_valid_q && (status_q == STAT_DELIVERED))
    else $error("non-final result without command byte");

endmodule

`default_nettype wire

FILE: hw/rtl/framed_command_buffer.sv
`default_nettype none

// framed command receive buffer. pushes (func 0) feed received bytes: outside a
// command, the start marker byte (register, reset 0x02) opens one; inside,
// every byte is stored in a 64-entry circular byte store if not full, and ';'
// closes the command. a push, a clear (func 2) or an unused code is taken in
// the idle state and gives one result; the next item is taken as soon as the
// output register is free or being drained. a pop (func 1) scans the store for
// the first ';', a read and a compare state per byte (one store read port with
// a registered read), removes the command and terminator by moving the head
// pointer, streams the command bytes, a read and a send state per byte, and
// closes with one summary result; with nothing pending or no ';' stored it
// gives one no-terminator result. a pop with a capacity not above the command
// length discards it without streaming. fill_level and overflow_seen on every
// result show the state after the item. no clearing pass after reset: only
// entries that were written are ever read. the user must write the start
// marker via cfg_we_i / cfg_wdata_i while idle; the block does not enforce it.
module framed_command_buffer
  import fcb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [BYTE_W-1:0]   cfg_wdata_i,
  // input item channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [BYTE_W-1:0]   data_byte_i,
  input  wire logic [CAP_W-1:0]    capacity_i,
  // result item channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic                     byte_valid_o,
  output logic                     last_o,
  output logic [LEN_W-1:0]         cmd_length_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FILL_W-1:0]        fill_level_o,
  output logic                     overflow_seen_o
);

  fcb_cmd_t  cmd;
  fcb_stat_t stat;

  // sequencing of scan, removal and streaming
  fcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // byte store, pointers, flags and output register
  fcb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .capacity_i      (capacity_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .cmd_length_o    (cmd_length_o),
    .status_o        (status_o),
    .fill_level_o    (fill_level_o),
    .overflow_seen_o (overflow_seen_o)
  );

endmodule

`default_nettype wire
